FILE: sv/rat_pkg.sv
package rat_pkg;

  // Default geometry and precision
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_FRAC_BITS = 16;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int LW_W       = 13;
  localparam int WIN_W      = 10;
  localparam int SENS_W     = 7;
  localparam int SUM_W      = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Arithmetic constants
  localparam int START_GAIN = 127;
  localparam int PIX_GAIN   = 200;
  localparam int SENS_FULL  = 100;

  // Register reset values
  localparam logic [LW_W-1:0]   LW_RST   = LW_W'(512);
  localparam logic [WIN_W-1:0]  WIN_RST  = WIN_W'(64);
  localparam logic [SENS_W-1:0] SENS_RST = SENS_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH  = 2'd0,
    REG_WINDOW_SIZE = 2'd1,
    REG_SENSITIVITY = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_MUL,
    ST_CMP
  } rat_state_e;

endpackage

FILE: sv/rat_if.sv
// Pixel input channel
interface rat_pix_if import rat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// Binarized result channel
interface rat_bw_if ();
  logic valid;
  logic ready;
  logic bw_bit;

  modport source (output valid, output bw_bit, input ready);
  modport sink   (input valid, input bw_bit, output ready);
endinterface

// Register write channel
interface rat_cfg_if import rat_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/running_average_adaptive_threshold.sv
// Running-average adaptive thresholder for 8-bit gray images in serpentine
// order (even rows left to right, odd rows right to left).
// pix_i takes one pixel per transaction; frame_start = 1 marks the first
// pixel of an image and restarts the running sum, column and row tracking.
// bw_o returns one bit per pixel: 1 white, 0 black, in input order.
// cfg_i writes line_width (0), window_size (1), sensitivity_percent (2);
// write only while no pixel is in flight. cfg_i is always ready.
// bw_o.valid rises once the pixel has passed through the sequencer: 34
// steps of the restoring divider (running sum / window size, one quotient bit per
// cycle), then update, multiply and compare. pix_i.ready is high only while
// the sequencer is idle, so a new pixel is taken only after the previous one
// has left the compare step. The result sits in an output register; the next
// pixel is taken while it waits, and only the final compare step holds if
// the previous result has still not been taken.
// Reset loads the default registers (512, 64, 15), the start sum 127*64 and
// clears position tracking; the line store needs no clearing, as the first
// row of every frame uses the start sum in place of the stored sums.
module running_average_adaptive_threshold import rat_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rat_pix_if.sink    pix_i,
  rat_bw_if.source   bw_o,
  rat_cfg_if.sink    cfg_i
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int STW    = (17 + FRAC_BITS > SUM_W) ? 17 + FRAC_BITS : SUM_W + 1;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int LHS_W  = PIX_W + 8 + WIN_W;
  localparam int RHS_W  = SENS_W + SUM_W + 1;
  localparam int CMP_W  = (LHS_W + FRAC_BITS > RHS_W) ? LHS_W + FRAC_BITS : RHS_W;
  localparam logic [STW-1:0] RST_WIDE =
    STW'(STW'(START_GAIN) * STW'(WIN_RST)) << FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_RST =
    (|RST_WIDE[STW-1:SUM_W]) ? '1 : RST_WIDE[SUM_W-1:0];

  // Configuration registers
  logic [LW_W-1:0]   lw_q;
  logic [WIN_W-1:0]  win_q;
  logic [SENS_W-1:0] sens_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q   <= LW_RST;
      win_q  <= WIN_RST;
      sens_q <= SENS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_LINE_WIDTH:  lw_q   <= cfg_i.wdata[LW_W-1:0];
        REG_WINDOW_SIZE: win_q  <= cfg_i.wdata[WIN_W-1:0];
        REG_SENSITIVITY: sens_q <= cfg_i.wdata[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings
  logic [WIN_W-1:0]  s_eff;
  logic [WW-1:0]     w_eff;
  logic [SENS_W-1:0] t_eff;
  logic [SENS_W-1:0] k_gain;
  logic [STW-1:0]    start_wide;
  logic [SUM_W-1:0]  start_sum;

  assign s_eff  = (win_q == '0) ? WIN_W'(1) : win_q;
  assign w_eff  = (lw_q == '0) ? WW'(1)
                : (32'(lw_q) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(lw_q);
  assign t_eff  = (sens_q > SENS_W'(SENS_FULL)) ? SENS_W'(SENS_FULL) : sens_q;
  assign k_gain = SENS_W'(SENS_FULL) - t_eff;
  assign start_wide = STW'(STW'(s_eff) * STW'(START_GAIN)) << FRAC_BITS;
  assign start_sum  = (|start_wide[STW-1:SUM_W]) ? '1 : start_wide[SUM_W-1:0];

  // State
  rat_state_e        state_q, state_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [AW-1:0]     col_q, col_d;
  logic              rev_q, rev_d;
  logic              frow_q, frow_d;
  logic              out_valid_q, out_valid_d;

  // Per-pixel working registers
  logic [SUM_W-1:0]  dq_q, dq_d;
  logic [WIN_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PIX_W-1:0]  p_q, p_d;
  logic [LHS_W-1:0]  lhs_q, lhs_d;
  logic [RHS_W-1:0]  rhs_q, rhs_d;
  logic [AW-1:0]     x_q, x_d;
  logic              first_q, first_d;
  logic              bw_q, bw_d;

  // Position of the incoming pixel
  logic [AW-1:0]     cur_col, col_fix;
  logic              cur_rev, cur_frow;
  logic [SUM_W-1:0]  cur_sum;
  logic [AW-1:0]     x_cur;
  logic [WW-1:0]     col_inc;

  assign cur_col  = pix_i.frame_start ? '0 : col_q;
  assign cur_rev  = pix_i.frame_start ? 1'b0 : rev_q;
  assign cur_frow = pix_i.frame_start ? 1'b1 : frow_q;
  assign cur_sum  = pix_i.frame_start ? start_sum : sum_q;
  assign col_fix  = (WW'(cur_col) >= w_eff) ? AW'(w_eff - WW'(1)) : cur_col;
  assign x_cur    = cur_rev ? AW'(w_eff - WW'(1) - WW'(col_fix)) : col_fix;
  assign col_inc  = WW'(col_fix) + WW'(1);

  // Divider step: one quotient bit per cycle
  logic [WIN_W:0]    rem_sh;
  logic              q_bit;

  assign rem_sh = {rem_q, dq_q[SUM_W-1]};
  assign q_bit  = rem_sh >= {1'b0, s_eff};

  // Sum update and threshold arithmetic
  logic [SUM_W:0]    new_wide;
  logic [SUM_W-1:0]  new_sum;
  logic [SUM_W-1:0]  above;
  logic [SUM_W-1:0]  ram_rd_data;
  logic [SUM_W:0]    tot;
  logic              ram_rd_en, ram_wr_en;

  assign new_wide = (SUM_W+1)'(sum_q - dq_q) + ((SUM_W+1)'(p_q) << FRAC_BITS);
  assign new_sum  = new_wide[SUM_W] ? '1 : new_wide[SUM_W-1:0];
  assign above    = first_q ? start_sum : ram_rd_data;
  assign tot      = (SUM_W+1)'(sum_q) + (SUM_W+1)'(above);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    col_d       = col_q;
    rev_d       = rev_q;
    frow_d      = frow_q;
    out_valid_d = out_valid_q && !bw_o.ready;
    dq_d        = dq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    x_d         = x_q;
    first_d     = first_q;
    bw_d        = bw_q;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (pix_i.valid) begin
          sum_d     = cur_sum;
          dq_d      = cur_sum;
          rem_d     = '0;
          cnt_d     = CNT_W'(SUM_W - 1);
          p_d       = pix_i.pixel;
          lhs_d     = LHS_W'(pix_i.pixel) * LHS_W'(PIX_GAIN) * LHS_W'(s_eff);
          x_d       = x_cur;
          first_d   = cur_frow;
          ram_rd_en = 1'b1;
          if (col_inc >= w_eff) begin
            col_d  = '0;
            rev_d  = !cur_rev;
            frow_d = 1'b0;
          end else begin
            col_d  = AW'(col_inc);
            rev_d  = cur_rev;
            frow_d = cur_frow;
          end
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = q_bit ? WIN_W'(rem_sh - {1'b0, s_eff}) : WIN_W'(rem_sh);
        dq_d  = {dq_q[SUM_W-2:0], q_bit};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d     = new_sum;
        ram_wr_en = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        rhs_d   = RHS_W'(k_gain) * RHS_W'(tot);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!out_valid_q || bw_o.ready) begin
          bw_d        = (CMP_W'(lhs_q) << FRAC_BITS) >= CMP_W'(rhs_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= SUM_RST;
      col_q       <= '0;
      rev_q       <= 1'b0;
      frow_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      col_q       <= col_d;
      rev_q       <= rev_d;
      frow_q      <= frow_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    p_q     <= p_d;
    lhs_q   <= lhs_d;
    rhs_q   <= rhs_d;
    x_q     <= x_d;
    first_q <= first_d;
    bw_q    <= bw_d;
  end

  // Line store of the previous row's sums
  rat_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (x_q),
    .wr_data_i (new_sum),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (x_cur),
    .rd_data_o (ram_rd_data)
  );

  assign pix_i.ready = (state_q == ST_IDLE);
  assign bw_o.valid  = out_valid_q;
  assign bw_o.bw_bit = bw_q;

endmodule

FILE: sv/rat_ram.sv
module rat_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
